// ===== hdl/svm_pkg.sv =====
// Shared types and constants for the saturating voice mixer.
package svm_pkg;

	// Table size and block length.
	localparam int VOICE_SLOTS   = 8;
	localparam int BLOCK_SAMPLES = 256;

	// Widths derived from the sizes above.
	localparam int SLOT_W  = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
	localparam int TOTAL_W = $clog2(VOICE_SLOTS + 1);
	localparam int BLK_W   = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

	// Saturation limits of the 16-bit output.
	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

	// Input operation codes.
	localparam logic [1:0] OP_PLAY   = 2'd0;
	localparam logic [1:0] OP_NEXT   = 2'd1;
	localparam logic [1:0] OP_RETURN = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_FETCH   = 2'd1;
	localparam logic [1:0] KIND_MIXED   = 2'd2;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	// One input word.
	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        source_id;
		logic [15:0]        sample_count;
		logic signed [15:0] sample_value;
	} in_t;

	// One result word.
	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        fetch_source;
		logic [15:0]        fetch_position;
		logic signed [15:0] mixed_sample;
		logic               end_of_block;
		logic               play_accepted;
		logic [3:0]         active_voices;
	} out_t;

	// One voice table entry.
	typedef struct packed {
		logic [15:0] source;
		logic [15:0] length;
		logic [15:0] position;
	} voice_t;

	// Write request into the voice table.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		voice_t            data;
	} tbl_wr_t;

endpackage

// ===== hdl/saturating_voice_mixer.sv =====
// Voice mixer top level. A small sequencer walks the voice table one slot per
// cycle through a single compare and increment unit. A play word is decoded
// and the table is then searched slot by slot for its handle; a new handle is
// entered past the last slot. A dropped or ignored word answers straight from
// the decode. A next-sample word scans slot by slot until the next running
// voice or the end of the table; a returned-sample word first advances the
// fetched voice and then scans on from the slot after it. On the last sample
// of a block the finished voices are then removed from the top slot down,
// each slot checked in turn and each finished voice replaced by the last one.
// Each word gives exactly one result, held in an output register; the next
// word is taken only when the sequencer is idle.
module saturating_voice_mixer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  svm_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output svm_pkg::out_t rsp
);

	localparam int TW = svm_pkg::TOTAL_W;
	localparam int SW = svm_pkg::SLOT_W;
	localparam int BW = svm_pkg::BLK_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAY_SCAN,
		ST_BUMP,
		ST_SCAN,
		ST_DROP_CHK,
		ST_DROP_MOVE
	} state_t;

	state_t             state_q;
	logic [TW-1:0]      total_q;
	logic [TW-1:0]      ptr_q;
	logic [TW-1:0]      hole_q;
	logic [TW-1:0]      cur_slot_q;
	logic               fetch_pending_q;
	logic [BW-1:0]      block_idx_q;
	logic signed [15:0] sum_q;
	logic [15:0]        src_q;
	logic [15:0]        cnt_q;
	logic               rsp_valid_q;
	svm_pkg::out_t      rsp_q;

	svm_pkg::voice_t    rd;
	svm_pkg::tbl_wr_t   tbl_wr;
	logic               running;
	logic               at_end;
	logic               match;
	logic signed [16:0] sum_wide;
	logic signed [15:0] sum_sat;

	svm_voice_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_idx  (ptr_q[SW-1:0]),
		.rd_data (rd)
	);

	// Shared compare unit on the slot under the pointer.
	assign running = rd.position < rd.length;
	assign at_end  = ptr_q >= total_q;
	assign match   = rd.source == src_q;

	// Saturating add of a returned sample.
	always_comb begin
		sum_wide = {sum_q[15], sum_q} + {req.sample_value[15], req.sample_value};
		if (sum_wide[16] != sum_wide[15]) begin
			sum_sat = sum_wide[16] ? svm_pkg::SAMPLE_MIN : svm_pkg::SAMPLE_MAX;
		end else begin
			sum_sat = sum_wide[15:0];
		end
	end

	// Table writes requested by the sequencer.
	always_comb begin
		tbl_wr      = '0;
		tbl_wr.idx  = ptr_q[SW-1:0];
		tbl_wr.data = rd;
		case (state_q)
			ST_PLAY_SCAN: begin
				if (at_end) begin
					tbl_wr.en   = 1'b1;
					tbl_wr.idx  = total_q[SW-1:0];
					tbl_wr.data = '{source: src_q, length: cnt_q, position: 16'd0};
				end else if (match) begin
					tbl_wr.en            = 1'b1;
					tbl_wr.data.position = 16'd0;
				end
			end
			ST_BUMP: begin
				if (running) begin
					tbl_wr.en            = 1'b1;
					tbl_wr.data.position = rd.position + 16'd1;
				end
			end
			ST_DROP_MOVE: begin
				tbl_wr.en  = 1'b1;
				tbl_wr.idx = hole_q[SW-1:0];
			end
			default: begin
				tbl_wr.en = 1'b0;
			end
		endcase
	end

	// Result word with every field cleared but kind and voice count.
	function automatic svm_pkg::out_t base_rsp(input logic [1:0] kind,
			input logic [TW-1:0] total);
		svm_pkg::out_t r;
		r               = '0;
		r.kind          = kind;
		r.active_voices = 4'(total);
		return r;
	endfunction

	// Acknowledge of a voice that was entered or restarted.
	function automatic svm_pkg::out_t accepted_rsp(input logic [TW-1:0] total);
		svm_pkg::out_t r;
		r               = base_rsp(svm_pkg::KIND_ACK, total);
		r.play_accepted = 1'b1;
		return r;
	endfunction

	// Request for the current sample of one voice.
	function automatic svm_pkg::out_t fetch_rsp(input svm_pkg::voice_t v,
			input logic [TW-1:0] total);
		svm_pkg::out_t r;
		r                = base_rsp(svm_pkg::KIND_FETCH, total);
		r.fetch_source   = v.source;
		r.fetch_position = v.position;
		return r;
	endfunction

	// Finished output sample, flagged on the last one of a block.
	function automatic svm_pkg::out_t mixed_rsp(input logic signed [15:0] sample,
			input logic eob, input logic [TW-1:0] total);
		svm_pkg::out_t r;
		r              = base_rsp(svm_pkg::KIND_MIXED, total);
		r.mixed_sample = sample;
		r.end_of_block = eob;
		return r;
	endfunction

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer, table bookkeeping and the output register. The output
	// register is always empty while the sequencer is busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			total_q         <= '0;
			ptr_q           <= '0;
			hole_q          <= '0;
			cur_slot_q      <= '0;
			fetch_pending_q <= 1'b0;
			block_idx_q     <= '0;
			sum_q           <= '0;
			src_q           <= '0;
			cnt_q           <= '0;
			rsp_valid_q     <= 1'b0;
			rsp_q           <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						case (req.op)
							svm_pkg::OP_PLAY: begin
								if (fetch_pending_q) begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= base_rsp(svm_pkg::KIND_IGNORED, total_q);
								end else if (total_q >= TW'(svm_pkg::VOICE_SLOTS)) begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= base_rsp(svm_pkg::KIND_ACK, total_q);
								end else begin
									rsp_valid_q <= 1'b0;
									src_q       <= req.source_id;
									cnt_q       <= req.sample_count;
									ptr_q       <= '0;
									state_q     <= ST_PLAY_SCAN;
								end
							end
							svm_pkg::OP_NEXT: begin
								if (fetch_pending_q) begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= base_rsp(svm_pkg::KIND_IGNORED, total_q);
								end else begin
									rsp_valid_q <= 1'b0;
									sum_q       <= '0;
									ptr_q       <= '0;
									state_q     <= ST_SCAN;
								end
							end
							svm_pkg::OP_RETURN: begin
								if (!fetch_pending_q) begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= base_rsp(svm_pkg::KIND_IGNORED, total_q);
								end else begin
									rsp_valid_q <= 1'b0;
									sum_q       <= sum_sat;
									ptr_q       <= cur_slot_q;
									state_q     <= ST_BUMP;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= base_rsp(svm_pkg::KIND_IGNORED, total_q);
							end
						endcase
					end else if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				// Look for the handle; enter a new voice past the last slot.
				ST_PLAY_SCAN: begin
					if (at_end) begin
						total_q     <= total_q + TW'(1);
						rsp_valid_q <= 1'b1;
						rsp_q       <= accepted_rsp(total_q + TW'(1));
						state_q     <= ST_IDLE;
					end else if (match) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= accepted_rsp(total_q);
						state_q     <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + TW'(1);
					end
				end
				// The table write advances the fetched voice's position.
				ST_BUMP: begin
					ptr_q   <= ptr_q + TW'(1);
					state_q <= ST_SCAN;
				end
				// Find the next running voice or close the sample.
				ST_SCAN: begin
					if (at_end) begin
						fetch_pending_q <= 1'b0;
						cur_slot_q      <= '0;
						if (block_idx_q == BW'(svm_pkg::BLOCK_SAMPLES - 1)) begin
							block_idx_q <= '0;
							if (total_q == '0) begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= mixed_rsp(sum_q, 1'b1, total_q);
								state_q     <= ST_IDLE;
							end else begin
								ptr_q   <= total_q - TW'(1);
								state_q <= ST_DROP_CHK;
							end
						end else begin
							block_idx_q <= block_idx_q + BW'(1);
							rsp_valid_q <= 1'b1;
							rsp_q       <= mixed_rsp(sum_q, 1'b0, total_q);
							state_q     <= ST_IDLE;
						end
					end else if (running) begin
						cur_slot_q      <= ptr_q;
						fetch_pending_q <= 1'b1;
						rsp_valid_q     <= 1'b1;
						rsp_q           <= fetch_rsp(rd, total_q);
						state_q         <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + TW'(1);
					end
				end
				// End of block: check slots from the top down.
				ST_DROP_CHK: begin
					if (!running) begin
						hole_q  <= ptr_q;
						ptr_q   <= total_q - TW'(1);
						state_q <= ST_DROP_MOVE;
					end else if (ptr_q == '0) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= mixed_rsp(sum_q, 1'b1, total_q);
						state_q     <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q - TW'(1);
					end
				end
				// The last voice is copied into the finished voice's slot.
				ST_DROP_MOVE: begin
					total_q <= total_q - TW'(1);
					if (hole_q == '0) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= mixed_rsp(sum_q, 1'b1, total_q - TW'(1));
						state_q     <= ST_IDLE;
					end else begin
						ptr_q   <= hole_q - TW'(1);
						state_q <= ST_DROP_CHK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A pending fetch always points at a slot that holds a voice.
	assert property (@(posedge clk) disable iff (!arst_n)
		fetch_pending_q |-> (cur_slot_q < total_q))
		else $error("pending fetch points past the voice table");

	// The table never holds more voices than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(svm_pkg::VOICE_SLOTS))
		else $error("voice count exceeds the table size");

	// A fetch request on the output leaves a fetch pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.kind == svm_pkg::KIND_FETCH)) |-> fetch_pending_q)
		else $error("fetch request shown without a pending fetch");
`endif

endmodule

// ===== hdl/svm_voice_table.sv =====
// Voice table: one entry per slot, one write port and one read port.
module svm_voice_table (
	input  logic                       clk,
	input  svm_pkg::tbl_wr_t           wr,
	input  logic [svm_pkg::SLOT_W-1:0] rd_idx,
	output svm_pkg::voice_t            rd_data
);

	svm_pkg::voice_t entry_q [svm_pkg::VOICE_SLOTS];

	// Entries are written by the sequencer one at a time.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			entry_q[wr.idx] <= wr.data;
		end
	end

	// The sequencer looks at one slot per cycle.
	assign rd_data = entry_q[rd_idx];

endmodule

// ===== test/saturating_voice_mixer_test.sv =====
// Self-checking testbench for the saturating voice mixer.
`timescale 1ns / 100ps

module saturating_voice_mixer_test;

	// Op code 3 has no meaning in the block and must be ignored.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int unsigned RANDOM_ITEMS  = 1400;
	localparam int unsigned MIN_WRAPS     = 1;
	localparam int unsigned DRAIN_EVERY   = 350;
	localparam int unsigned SETTLE_CYCLES = 3 * svm_pkg::VOICE_SLOTS + 8;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	svm_pkg::in_t  req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	svm_pkg::out_t rsp;

	// Expected result words, oldest first.
	svm_pkg::out_t mixer_results_due[$];

	// Mirror of the voice table and the mixing state.
	logic [15:0] voice_src[svm_pkg::VOICE_SLOTS];
	logic [15:0] voice_len[svm_pkg::VOICE_SLOTS];
	logic [15:0] voice_pos[svm_pkg::VOICE_SLOTS];
	int unsigned voice_count = 0;
	int unsigned block_pos = 0;
	int          mix_sum = 0;
	int unsigned fetch_slot = 0;
	bit          awaiting_return = 1'b0;

	int unsigned block_wraps = 0;
	int unsigned useful_items = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 1;
	int          stall_mode = 0;
	int unsigned stall_left = 0;

	saturating_voice_mixer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit; a hang ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver switches between randomly chosen stall patterns.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(40, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			2: rsp_ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ready <= (cycle_count % 3 != 0);
		endcase
	end

	// Result word with kind and table occupancy filled in, other fields zero.
	function automatic svm_pkg::out_t blank_result(logic [1:0] kind);
		svm_pkg::out_t r;
		r = '0;
		r.kind = kind;
		r.active_voices = 4'(voice_count);
		return r;
	endfunction

	// Find the next running voice from a slot on, or close the output sample.
	function automatic svm_pkg::out_t scan_voices(int unsigned from);
		svm_pkg::out_t r;
		int unsigned   last;
		bit            wrap;
		for (int unsigned s = from; s < voice_count && s < svm_pkg::VOICE_SLOTS; s++) begin
			if (voice_pos[s] < voice_len[s]) begin
				fetch_slot = s;
				awaiting_return = 1'b1;
				r = blank_result(svm_pkg::KIND_FETCH);
				r.fetch_source = voice_src[s];
				r.fetch_position = voice_pos[s];
				return r;
			end
		end
		awaiting_return = 1'b0;
		fetch_slot = 0;
		wrap = 1'b0;
		block_pos++;
		if (block_pos >= svm_pkg::BLOCK_SAMPLES) begin
			block_pos = 0;
			wrap = 1'b1;
			block_wraps++;
			// Finished voices go from the top slot down; the last voice fills the hole.
			for (int i = int'(voice_count) - 1; i >= 0; i--) begin
				if (voice_pos[i] >= voice_len[i]) begin
					last = voice_count - 1;
					voice_src[i] = voice_src[last];
					voice_len[i] = voice_len[last];
					voice_pos[i] = voice_pos[last];
					voice_count = last;
				end
			end
		end
		r = blank_result(svm_pkg::KIND_MIXED);
		r.mixed_sample = 16'(mix_sum);
		r.end_of_block = wrap;
		return r;
	endfunction

	// Expected result of one input word; updates the mirrored state.
	function automatic svm_pkg::out_t predict_mixer_result(svm_pkg::in_t w);
		svm_pkg::out_t r;
		bit            known;
		int unsigned   s;
		case (w.op)
			svm_pkg::OP_PLAY: begin
				if (awaiting_return) begin
					r = blank_result(svm_pkg::KIND_IGNORED);
				end else if (voice_count >= svm_pkg::VOICE_SLOTS) begin
					r = blank_result(svm_pkg::KIND_ACK);
				end else begin
					known = 1'b0;
					for (int unsigned i = 0; i < voice_count; i++) begin
						if (!known && voice_src[i] == w.source_id) begin
							voice_pos[i] = '0;
							known = 1'b1;
						end
					end
					if (!known) begin
						voice_src[voice_count] = w.source_id;
						voice_len[voice_count] = w.sample_count;
						voice_pos[voice_count] = '0;
						voice_count++;
					end
					r = blank_result(svm_pkg::KIND_ACK);
					r.play_accepted = 1'b1;
				end
			end
			svm_pkg::OP_NEXT: begin
				if (awaiting_return) begin
					r = blank_result(svm_pkg::KIND_IGNORED);
				end else begin
					mix_sum = 0;
					r = scan_voices(0);
				end
			end
			svm_pkg::OP_RETURN: begin
				if (!awaiting_return) begin
					r = blank_result(svm_pkg::KIND_IGNORED);
				end else begin
					s = fetch_slot;
					mix_sum = mix_sum + int'(w.sample_value);
					if (mix_sum > int'(svm_pkg::SAMPLE_MAX))
						mix_sum = int'(svm_pkg::SAMPLE_MAX);
					if (mix_sum < int'(svm_pkg::SAMPLE_MIN))
						mix_sum = int'(svm_pkg::SAMPLE_MIN);
					if (s < svm_pkg::VOICE_SLOTS && voice_pos[s] < voice_len[s])
						voice_pos[s] = voice_pos[s] + 16'd1;
					r = scan_voices(s + 1);
				end
			end
			default: r = blank_result(svm_pkg::KIND_IGNORED);
		endcase
		return r;
	endfunction

	// Send one word; valid stays high across a burst and drops for the gaps.
	task automatic send_word(svm_pkg::in_t w);
		svm_pkg::out_t want;
		want = predict_mixer_result(w);
		mixer_results_due.push_back(want);
		if (want.kind != svm_pkg::KIND_IGNORED)
			useful_items++;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic send_fields(logic [1:0] op, logic [15:0] src, logic [15:0] cnt,
		logic [15:0] value);
		svm_pkg::in_t w;
		w.op = op;
		w.source_id = src;
		w.sample_count = cnt;
		w.sample_value = value;
		send_word(w);
	endtask

	// Hold off the sender until every expected word has come back.
	task automatic wait_results_done();
		req_valid <= 1'b0;
		while (mixer_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin : check_results
		svm_pkg::out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (mixer_results_due.size() == 0) begin
				$error("result word with none expected: kind %0d", rsp.kind);
				fail_count++;
			end else begin
				want = mixer_results_due.pop_front();
				check_field("kind", want.kind, rsp.kind);
				check_field("fetch_source", want.fetch_source, rsp.fetch_source);
				check_field("fetch_position", want.fetch_position, rsp.fetch_position);
				check_field("mixed_sample", want.mixed_sample, rsp.mixed_sample);
				check_field("end_of_block", want.end_of_block, rsp.end_of_block);
				check_field("play_accepted", want.play_accepted, rsp.play_accepted);
				check_field("active_voices", want.active_voices, rsp.active_voices);
			end
		end
	end

	// Returned samples lean toward the limits so the sum saturates often.
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 16));
			3: return 16'(-$urandom_range(0, 16));
			default: return 16'($urandom);
		endcase
	endfunction

	// A small pool of handles makes repeated plays of a known voice common.
	function automatic logic [15:0] pick_handle();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 16'h0100 + 16'($urandom_range(0, 11));
		if (roll < 70)
			return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
		return 16'($urandom);
	endfunction

	// Mostly short voices so they finish and leave the table at block ends.
	// Long ones never finish, so they only come late in the run.
	function automatic logic [15:0] pick_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 16'($urandom_range(0, 8));
		if (roll < 85)
			return 16'($urandom_range(9, 40));
		if (roll < 95 || block_wraps < 1)
			return 16'($urandom_range(41, 300));
		return 16'($urandom);
	endfunction

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_fields(svm_pkg::OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom));
			1: send_fields(svm_pkg::OP_NEXT, 16'($urandom), 16'($urandom), 16'($urandom));
			2: send_fields(svm_pkg::OP_RETURN, 16'($urandom), 16'($urandom), 16'($urandom));
			default: send_fields(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
		endcase
	endtask

	// Empty table: a sample of zero at once, a stray return and an unused op.
	task automatic test_empty_table();
		send_fields(svm_pkg::OP_NEXT, 16'h0000, 16'h0000, 16'h0000);
		send_fields(svm_pkg::OP_RETURN, 16'hffff, 16'hffff, 16'h7fff);
		send_fields(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff);
	endtask

	// Three voices, one of zero length and one that never ends; words sent
	// mid-sample are ignored, the sum clamps both ways, a known handle restarts.
	task automatic test_play_and_mix();
		send_fields(svm_pkg::OP_PLAY, 16'h0000, 16'd2, 16'h0000);
		send_fields(svm_pkg::OP_PLAY, 16'h1234, 16'd0, 16'h0000);
		send_fields(svm_pkg::OP_PLAY, 16'hffff, 16'hffff, 16'hffff);
		send_fields(svm_pkg::OP_NEXT, 16'h0000, 16'h0000, 16'h0000);
		send_fields(svm_pkg::OP_PLAY, 16'habcd, 16'd5, 16'h0000);
		send_fields(svm_pkg::OP_NEXT, 16'h0000, 16'h0000, 16'h0000);
		send_fields(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000);
		send_fields(svm_pkg::OP_RETURN, 16'h5a5a, 16'ha5a5, 16'h7fff);
		send_fields(svm_pkg::OP_RETURN, 16'ha5a5, 16'h5a5a, 16'h7fff);
		send_fields(svm_pkg::OP_NEXT, 16'h0000, 16'h0000, 16'h0000);
		send_fields(svm_pkg::OP_RETURN, 16'h0000, 16'h0000, 16'h8000);
		send_fields(svm_pkg::OP_RETURN, 16'h0000, 16'h0000, 16'h8000);
		send_fields(svm_pkg::OP_PLAY, 16'h0000, 16'h0f0f, 16'h0000);
	endtask

	// Fill the table, then a new and a known handle are both dropped.
	task automatic test_table_full();
		for (int unsigned i = 0; i < svm_pkg::VOICE_SLOTS - 3; i++)
			send_fields(svm_pkg::OP_PLAY, 16'h2000 + 16'(i), 16'($urandom_range(0, 3)),
				16'h0000);
		send_fields(svm_pkg::OP_PLAY, 16'h5555, 16'd7, 16'h0000);
		send_fields(svm_pkg::OP_PLAY, 16'h0000, 16'd7, 16'h0000);
	endtask

	// Mostly complete samples with random content, some noise, and at least
	// one block end so finished voices get removed.
	task automatic test_random_traffic();
		int unsigned start_items;
		int unsigned drain_mark;
		int unsigned roll;
		start_items = useful_items;
		drain_mark = useful_items;
		while (useful_items - start_items < RANDOM_ITEMS || block_wraps < MIN_WRAPS) begin
			roll = $urandom_range(0, 99);
			if (awaiting_return) begin
				if (roll < 6)
					send_noise();
				else
					send_fields(svm_pkg::OP_RETURN, 16'($urandom), 16'($urandom),
						pick_sample());
			end else if (roll < 6) begin
				send_fields(svm_pkg::OP_PLAY, pick_handle(), pick_length(), 16'($urandom));
			end else if (roll < 10) begin
				send_noise();
			end else begin
				send_fields(svm_pkg::OP_NEXT, 16'($urandom), 16'($urandom), 16'($urandom));
			end
			if (useful_items - drain_mark >= DRAIN_EVERY) begin
				wait_results_done();
				drain_mark = useful_items;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_play_and_mix();
		wait_results_done();
		test_table_full();
		test_random_traffic();
		wait_results_done();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/svm_pkg.sv
hdl/svm_voice_table.sv
hdl/saturating_voice_mixer.sv
test/saturating_voice_mixer_test.sv
